// ===== hw/rtl/omap_pkg.sv =====
// Shared constants and codes for the outlier-rejecting moving-average packer.
// No dependencies; the top level and the checker refer to it by scoped names.
package omap_pkg;

    // Averaging window, a power of two from 2 to 16
    localparam int WINDOW_SIZE = 2;
    localparam int LOG2W       = $clog2(WINDOW_SIZE);

    localparam int SAMPLE_W = 12;
    localparam int RAW_W    = 16;
    localparam int GROUP_W  = 2 * SAMPLE_W;
    localparam int SUM_W    = SAMPLE_W + LOG2W;
    localparam int WARM_W   = $clog2(WINDOW_SIZE + 1);
    localparam int SLOT_W   = (LOG2W > 0) ? LOG2W : 1;

    // Configuration port geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(3000);

    // Register indexes
    typedef enum logic [1:0] {
        REG_STREAM_ENABLE = 2'd0,
        REG_PROXIMITY     = 2'd1,
        REG_THRESHOLD     = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    // Request kinds
    typedef enum logic {
        ACT_SAMPLE  = 1'b0,
        ACT_RESTART = 1'b1
    } t_action;

endpackage

// ===== hw/rtl/outlier_moving_average_packer_top.sv =====
// Top level of the outlier-rejecting moving-average packer.
// Depends on omap_pkg for widths, register indexes and request codes.
//
// A request is registered in the input stage and its group in the result stage.
// Throughput: one request per cycle barring a stall; single registered window update.
// Reset: synchronous, active low; clears window, sum, pairing and control state,
// and sets the threshold register to 3000.
module outlier_moving_average_packer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [omap_pkg::RAW_W-1:0]        i_raw_sample,
    input  logic                              i_object_near,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [omap_pkg::GROUP_W-1:0]      o_packed_group,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [omap_pkg::PADDR_W-1:0]      paddr,
    input  logic [omap_pkg::PDATA_W-1:0]      pwdata,
    output logic [omap_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int SW = omap_pkg::SAMPLE_W;

    // configuration registers
    logic          r_stream_enable;
    logic          r_proximity_gate;
    logic [SW-1:0] r_threshold;

    // input stage
    logic                         r_in_valid;
    logic                         r_action;
    logic [SW-1:0]                r_sample;
    logic                         r_near;

    // filter state
    logic [SW-1:0]                 r_window [omap_pkg::WINDOW_SIZE];
    logic [omap_pkg::SUM_W-1:0]    r_sum;
    logic [omap_pkg::SLOT_W-1:0]   r_write_slot;
    logic [omap_pkg::WARM_W-1:0]   r_warm_count;
    logic                          r_average_ready;
    logic [SW-1:0]                 r_last_average;
    logic [SW-1:0]                 r_held_average;
    logic                          r_held_valid;

    // result stage
    logic                          r_out_valid;
    logic [omap_pkg::GROUP_W-1:0]  r_packed_group;

    logic                          advance;
    logic                          cfg_write;
    omap_pkg::t_reg_idx            reg_idx;

    logic                          take;
    logic [SW-1:0]                 diff;
    logic [SW-1:0]                 screened;
    logic [SW-1:0]                 old_entry;
    logic [omap_pkg::SUM_W-1:0]    n_sum;
    logic [SW-1:0]                 n_average;
    logic                          full;
    logic                          emit;

    // Pass the request on whenever the result slot is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = omap_pkg::t_reg_idx'(paddr[3:2]);

    // Read back the configuration
    always_comb begin
        case (reg_idx)
            omap_pkg::REG_STREAM_ENABLE: prdata = {31'd0, r_stream_enable};
            omap_pkg::REG_PROXIMITY:     prdata = {31'd0, r_proximity_gate};
            omap_pkg::REG_THRESHOLD:     prdata = {20'd0, r_threshold};
            default:                     prdata = '0;
        endcase
    end

    // Screen the sample and work out the new window sum
    always_comb begin
        take      = (r_action == omap_pkg::ACT_SAMPLE) && r_stream_enable
                    && (!r_proximity_gate || r_near);
        diff      = (r_sample >= r_last_average) ? (r_sample - r_last_average)
                                                 : (r_last_average - r_sample);
        screened  = (r_average_ready && (diff > r_threshold)) ? r_last_average : r_sample;
        old_entry = r_window[r_write_slot[omap_pkg::LOG2W-1:0]];
        n_sum     = r_sum - omap_pkg::SUM_W'(old_entry) + omap_pkg::SUM_W'(screened);
        n_average = n_sum[omap_pkg::SUM_W-1:omap_pkg::LOG2W];
        full      = (r_warm_count >= omap_pkg::WARM_W'(omap_pkg::WINDOW_SIZE - 1));
        emit      = take && full && r_held_valid;
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_enable  <= 1'b0;
            r_proximity_gate <= 1'b0;
            r_threshold      <= omap_pkg::THRESH_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                omap_pkg::REG_STREAM_ENABLE: r_stream_enable  <= pwdata[0];
                omap_pkg::REG_PROXIMITY:     r_proximity_gate <= pwdata[0];
                omap_pkg::REG_THRESHOLD:     r_threshold      <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_sample <= i_raw_sample[SW-1:0];
            r_near   <= i_object_near;
        end
    end

    // Update the window, the averages and the pairing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < omap_pkg::WINDOW_SIZE; i++) begin
                r_window[i] <= '0;
            end
            r_sum           <= '0;
            r_write_slot    <= '0;
            r_warm_count    <= '0;
            r_average_ready <= 1'b0;
            r_last_average  <= '0;
            r_held_average  <= '0;
            r_held_valid    <= 1'b0;
        end else if (advance) begin
            if (r_action == omap_pkg::ACT_RESTART) begin
                r_held_valid <= 1'b0;
            end else if (take) begin
                r_window[r_write_slot[omap_pkg::LOG2W-1:0]] <= screened;
                r_sum        <= n_sum;
                r_write_slot <= r_write_slot + 1'b1;
                if (!full) begin
                    r_warm_count <= r_warm_count + 1'b1;
                end
                if (full) begin
                    r_warm_count    <= omap_pkg::WARM_W'(omap_pkg::WINDOW_SIZE);
                    r_average_ready <= 1'b1;
                    r_last_average  <= n_average;
                    if (!r_held_valid) begin
                        r_held_average <= n_average;
                        r_held_valid   <= 1'b1;
                    end else begin
                        r_held_valid <= 1'b0;
                    end
                end
            end
        end
    end

    // Hold the group until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_packed_group <= {r_held_average, n_average};
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_packed_group = r_packed_group;

endmodule

// ===== hw/rtl/omap_checker.sv =====
// Port-level checks for the outlier-rejecting moving-average packer.
// Depends on omap_pkg; bound to outlier_moving_average_packer_top below.
module omap_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [omap_pkg::GROUP_W-1:0]  o_packed_group
);

    // Keep a stalled result offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Keep a stalled result unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_packed_group))
        else $error("result changed while stalled");

    // Never stall requests while the result slot is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request stalled with empty result slot");

    // A fresh result must follow an earlier accepted request
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without a request");

endmodule

bind outlier_moving_average_packer_top omap_checker u_omap_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_packed_group (o_packed_group)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the outlier-rejecting moving-average packer.
// Depends on omap_pkg and outlier_moving_average_packer_top; predicts each packed group
// in step with every accepted request and checks results in order.
module testbench;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;

    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_action = 1'b0;
    logic [omap_pkg::RAW_W-1:0]      i_raw_sample = '0;
    logic                            i_object_near = 1'b0;

    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [omap_pkg::GROUP_W-1:0]    o_packed_group;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [omap_pkg::PADDR_W-1:0]    paddr = '0;
    logic [omap_pkg::PDATA_W-1:0]    pwdata = '0;
    logic [omap_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;

    // Filter copy: configuration
    logic                            cfg_stream;
    logic                            cfg_gate;
    logic [omap_pkg::SAMPLE_W-1:0]   cfg_thresh;

    // Filter copy: window, sum and pairing state
    logic [omap_pkg::SAMPLE_W-1:0]   win_taps [omap_pkg::WINDOW_SIZE];
    logic [omap_pkg::SUM_W-1:0]      tap_sum;
    int                              tap_ptr;
    int                              fill_count;
    logic                            avg_seen;
    logic [omap_pkg::SAMPLE_W-1:0]   prev_avg;
    logic [omap_pkg::SAMPLE_W-1:0]   pend_avg;
    logic                            pend_valid;

    logic [omap_pkg::GROUP_W-1:0]    group_queue [$];
    int                              fail_count = 0;

    // Request sender bookkeeping
    int                              burst_left = 0;
    bit                              valid_high = 1'b0;

    // Receiver stall pattern
    int                              ready_hold = 0;

    outlier_moving_average_packer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_raw_sample   (i_raw_sample),
        .i_object_near  (i_object_near),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packed_group (o_packed_group),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    // Clear the filter copy to its reset state
    function automatic void clear_filter();
        cfg_stream = 1'b0;
        cfg_gate   = 1'b0;
        cfg_thresh = omap_pkg::THRESH_RESET;
        for (int k = 0; k < omap_pkg::WINDOW_SIZE; k++) begin
            win_taps[k] = '0;
        end
        tap_sum    = '0;
        tap_ptr    = 0;
        fill_count = 0;
        avg_seen   = 1'b0;
        prev_avg   = '0;
        pend_avg   = '0;
        pend_valid = 1'b0;
    endfunction

    // Advance the filter copy by one request; queue the group it completes
    function automatic void predict_group(input omap_pkg::t_action act,
                                          input logic [omap_pkg::RAW_W-1:0] raw,
                                          input logic near);
        logic [omap_pkg::SAMPLE_W-1:0] smp;
        logic [omap_pkg::SAMPLE_W-1:0] jump;
        logic [omap_pkg::SAMPLE_W-1:0] avg;
        smp = raw[omap_pkg::SAMPLE_W-1:0];
        if (act == omap_pkg::ACT_RESTART) begin
            pend_valid = 1'b0;
        end else if (cfg_stream && (!cfg_gate || near)) begin
            // Replace a jump beyond the threshold by the last average
            if (avg_seen) begin
                jump = (smp >= prev_avg) ? smp - prev_avg : prev_avg - smp;
                if (jump > cfg_thresh) smp = prev_avg;
            end
            tap_sum = tap_sum - omap_pkg::SUM_W'(win_taps[tap_ptr])
                      + omap_pkg::SUM_W'(smp);
            win_taps[tap_ptr] = smp;
            tap_ptr = (tap_ptr + 1) % omap_pkg::WINDOW_SIZE;
            if (fill_count < omap_pkg::WINDOW_SIZE) fill_count++;
            if (fill_count == omap_pkg::WINDOW_SIZE) begin
                avg      = omap_pkg::SAMPLE_W'(tap_sum >> omap_pkg::LOG2W);
                avg_seen = 1'b1;
                prev_avg = avg;
                if (!pend_valid) begin
                    pend_avg   = avg;
                    pend_valid = 1'b1;
                end else begin
                    pend_valid = 1'b0;
                    group_queue.push_back({pend_avg, avg});
                end
            end
        end
    endfunction

    function automatic void valid_hi_clear();
        valid_high = 1'b0;
        burst_left = 0;
    endfunction

    // Drop valid if it is still held high
    task automatic stop_requests();
        if (valid_high) begin
            i_in_valid <= 1'b0;
            valid_hi_clear();
        end
    endtask

    // Send one request, in bursts with idle gaps between them
    task automatic send_request(input omap_pkg::t_action act,
                                input logic [omap_pkg::RAW_W-1:0] raw,
                                input logic near);
        int gap;
        if (burst_left == 0) begin
            stop_requests();
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_raw_sample  <= raw;
        i_object_near <= near;
        valid_high = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_group(act, raw, near);
        burst_left--;
    endtask

    // Hold off until every expected group has arrived, then let the pipe settle
    task automatic drain_groups();
        int waited;
        stop_requests();
        waited = 0;
        while (group_queue.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        if (group_queue.size() != 0) begin
            $error("packed_group: %0d expected groups never arrived", group_queue.size());
            fail_count++;
            group_queue.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register through the configuration port; block must be idle
    task automatic write_register(input omap_pkg::t_reg_idx idx,
                                  input logic [omap_pkg::PDATA_W-1:0] data);
        logic [omap_pkg::PDATA_W-1:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= omap_pkg::PADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        want = '0;
        case (idx)
            omap_pkg::REG_STREAM_ENABLE: begin
                cfg_stream = data[0];
                want[0]    = data[0];
            end
            omap_pkg::REG_PROXIMITY: begin
                cfg_gate = data[0];
                want[0]  = data[0];
            end
            omap_pkg::REG_THRESHOLD: begin
                cfg_thresh                     = data[omap_pkg::SAMPLE_W-1:0];
                want[omap_pkg::SAMPLE_W-1:0]   = data[omap_pkg::SAMPLE_W-1:0];
            end
            default: ;
        endcase
        // Read the register back while the address is still held
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("prdata: expected %h, actual %h", want, prdata);
            fail_count++;
        end
    endtask

    task automatic configure(input logic stream, input logic gate,
                             input logic [omap_pkg::SAMPLE_W-1:0] thresh);
        drain_groups();
        write_register(omap_pkg::REG_STREAM_ENABLE, {$urandom} & ~32'h1 | 32'(stream));
        write_register(omap_pkg::REG_PROXIMITY, {$urandom} & ~32'h1 | 32'(gate));
        write_register(omap_pkg::REG_THRESHOLD, {$urandom} & ~32'hFFF | 32'(thresh));
    endtask

    function automatic logic [omap_pkg::RAW_W-1:0] sample_word(
        input logic [omap_pkg::SAMPLE_W-1:0] val);
        return {4'($urandom), val};
    endfunction

    // Samples with reset configuration: streaming is off, so nothing comes out
    task automatic test_disabled_after_reset();
        send_request(omap_pkg::ACT_SAMPLE, 16'hFFFF, 1'b1);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0123, 1'b0);
        send_request(omap_pkg::ACT_RESTART, 16'hFFFF, 1'b1);
        drain_groups();
    endtask

    // Warm-up, pairing, masking of the upper nibble and restart of the pairing
    task automatic test_pairing();
        configure(1'b1, 1'b0, 12'hFFF);
        send_request(omap_pkg::ACT_SAMPLE, 16'hFFFF, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0FFF, 1'b1);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0000, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'hF000, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0800, 1'b1);
        send_request(omap_pkg::ACT_RESTART, 16'h0000, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h07FF, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'hAFFF, 1'b1);
        send_request(omap_pkg::ACT_SAMPLE, 16'h5001, 1'b0);
        drain_groups();
    endtask

    // Proximity gating drops samples with no object near
    task automatic test_proximity_gate();
        configure(1'b1, 1'b1, 12'hFFF);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0444, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0222, 1'b1);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0FFF, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0666, 1'b1);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0111, 1'b1);
        drain_groups();
    endtask

    // Zero threshold replaces later samples by the last average; default threshold clips large jumps
    task automatic test_outlier_threshold();
        configure(1'b1, 1'b0, 12'h000);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0001, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0FFF, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0000, 1'b0);
        configure(1'b1, 1'b0, omap_pkg::THRESH_RESET);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0000, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0FFF, 1'b0);
        send_request(omap_pkg::ACT_SAMPLE, 16'h0BB8, 1'b0);
        drain_groups();
    endtask

    // Random requests under one configuration, mostly samples near the average
    task automatic test_random_phase(input int count, input logic stream, input logic gate,
                                     input logic [omap_pkg::SAMPLE_W-1:0] thresh);
        int pick;
        int spread;
        logic [omap_pkg::SAMPLE_W-1:0] val;
        logic near;
        configure(stream, gate, thresh);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            near = gate ? ($urandom_range(0, 4) != 0) : 1'($urandom);
            if (pick < 5) begin
                send_request(omap_pkg::ACT_RESTART, 16'($urandom), 1'($urandom));
            end else if (pick < 75) begin
                spread = (thresh == 0) ? 3 : int'(thresh) + 8;
                val = prev_avg
                      + omap_pkg::SAMPLE_W'($urandom_range(0, 2 * spread) - spread);
                send_request(omap_pkg::ACT_SAMPLE, sample_word(val), near);
            end else begin
                send_request(omap_pkg::ACT_SAMPLE, 16'($urandom), near);
            end
            // Hold off now and then until every group is out
            if ($urandom_range(0, 149) == 0) drain_groups();
        end
        drain_groups();
    endtask

    task automatic test_random();
        test_random_phase(220, 1'b1, 1'b0, 12'hFFF);
        test_random_phase(220, 1'b1, 1'b1, 12'h000);
        test_random_phase(60, 1'b0, 1'b1, omap_pkg::SAMPLE_W'($urandom));
        test_random_phase(220, 1'b1, 1'b0, omap_pkg::THRESH_RESET);
        test_random_phase(220, 1'b1, 1'b1, omap_pkg::SAMPLE_W'($urandom_range(1, 64)));
        test_random_phase(220, 1'b1, 1'b0, omap_pkg::SAMPLE_W'($urandom));
        test_random_phase(150, 1'b1, 1'b1, omap_pkg::SAMPLE_W'($urandom_range(500, 4094)));
    endtask

    // Receiver: stall on a pattern of runs; check each accepted group in order
    always @(posedge i_clk) begin : check_groups
        logic [omap_pkg::GROUP_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (group_queue.size() == 0) begin
                $error("packed_group: unexpected result, actual %h", o_packed_group);
                fail_count++;
            end else begin
                want = group_queue.pop_front();
                if (o_packed_group !== want) begin
                    $error("packed_group: expected %h, actual %h", want, o_packed_group);
                    fail_count++;
                end
            end
        end
        if (ready_hold == 0) begin
            if ($urandom_range(0, 9) < 6) begin
                i_out_ready <= 1'b1;
                ready_hold = $urandom_range(1, 30);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold = $urandom_range(1, 8);
            end
        end else begin
            ready_hold--;
        end
    end

    initial begin
        clear_filter();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_after_reset();
        test_pairing();
        test_proximity_gate();
        test_outlier_threshold();
        test_random();
        drain_groups();
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Give up after a generous fixed time
    initial begin
        #3000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
